@@ sv/wnma_pkg.sv @@
// ----------------------------------------------------------------------------
// wnma_pkg: shared types and constants of the wall neighbour mask autotiler
// Field widths, configuration register indexes, reset values and the bit
// positions of the neighbour mask.
// ----------------------------------------------------------------------------
package wnma_pkg;

  localparam int CODE_W        = 8;
  localparam int GRID_WIDTH_W  = 11;
  localparam int COORD_W       = 10;
  localparam int MASK_W        = 8;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_WIDTH    = 8'd0,
    REG_WALL_CODE     = 8'd1,
    REG_FLOOR_CODE    = 8'd2,
    REG_CORRIDOR_CODE = 8'd3
  } cfg_reg_t;

  localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RST    = 11'd64;
  localparam logic [CODE_W-1:0]       WALL_CODE_RST     = 8'd1;
  localparam logic [CODE_W-1:0]       FLOOR_CODE_RST    = 8'd2;
  localparam logic [CODE_W-1:0]       CORRIDOR_CODE_RST = 8'd3;

  // Bit positions in the neighbour mask.
  localparam int DIR_E  = 0;
  localparam int DIR_S  = 1;
  localparam int DIR_W  = 2;
  localparam int DIR_N  = 3;
  localparam int DIR_SE = 4;
  localparam int DIR_SW = 5;
  localparam int DIR_NW = 6;
  localparam int DIR_NE = 7;

  typedef struct packed {
    logic [GRID_WIDTH_W-1:0] grid_width;
    logic [CODE_W-1:0]       wall_code;
    logic [CODE_W-1:0]       floor_code;
    logic [CODE_W-1:0]       corridor_code;
  } cfg_regs_t;

  // Classification of one cell.
  typedef struct packed {
    logic wall;
    logic walk;
  } cell_bits_t;

  // One line store word: walkable bit of row r-2 and both bits of row r-1.
  typedef struct packed {
    logic       upper_walk;
    cell_bits_t centre;
  } store_word_t;

  // The column that enters the window with an item.
  typedef struct packed {
    logic       upper_walk;
    cell_bits_t centre;
    logic       lower_walk;
  } win_col_t;

endpackage

@@ sv/wnma_if.sv @@
// ----------------------------------------------------------------------------
// wnma_if: channel interfaces of the wall neighbour mask autotiler
// Cell input stream, mask result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface wnma_cell_if;
  logic                        valid;
  logic                        ready;
  logic [wnma_pkg::CODE_W-1:0] cell_code;
  logic                        frame_start;
  logic                        flush_item;

  modport source (output valid, cell_code, frame_start, flush_item, input ready);
  modport sink (input valid, cell_code, frame_start, flush_item, output ready);
endinterface

interface wnma_mask_if;
  logic                         valid;
  logic                         ready;
  logic [wnma_pkg::MASK_W-1:0]  neighbour_mask;
  logic                         centre_is_wall;
  logic [wnma_pkg::COORD_W-1:0] cell_col;
  logic [wnma_pkg::COORD_W-1:0] cell_row;

  modport source (output valid, neighbour_mask, centre_is_wall, cell_col, cell_row,
                  input ready);
  modport sink (input valid, neighbour_mask, centre_is_wall, cell_col, cell_row,
                output ready);
endinterface

interface wnma_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wnma_pkg::CFG_INDEX_W-1:0] index;
  logic [wnma_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/wnma_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// wnma_cfg_regs: configuration register file
// Holds grid width and the three cell codes; written by index.
// ----------------------------------------------------------------------------
module wnma_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [wnma_pkg::CFG_INDEX_W-1:0] index,
  input  logic [wnma_pkg::CFG_DATA_W-1:0]  data,
  output wnma_pkg::cfg_regs_t              regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.grid_width    <= wnma_pkg::GRID_WIDTH_RST;
      regs.wall_code     <= wnma_pkg::WALL_CODE_RST;
      regs.floor_code    <= wnma_pkg::FLOOR_CODE_RST;
      regs.corridor_code <= wnma_pkg::CORRIDOR_CODE_RST;
    end else if (we) begin
      case (index)
        wnma_pkg::REG_GRID_WIDTH: begin
          regs.grid_width <= data[wnma_pkg::GRID_WIDTH_W-1:0];
        end
        wnma_pkg::REG_WALL_CODE: begin
          regs.wall_code <= data[wnma_pkg::CODE_W-1:0];
        end
        wnma_pkg::REG_FLOOR_CODE: begin
          regs.floor_code <= data[wnma_pkg::CODE_W-1:0];
        end
        wnma_pkg::REG_CORRIDOR_CODE: begin
          regs.corridor_code <= data[wnma_pkg::CODE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/wnma_scan_ctr.sv @@
// ----------------------------------------------------------------------------
// wnma_scan_ctr: raster position counters
// Gives the column and row of the item being accepted and advances on accept.
// ----------------------------------------------------------------------------
module wnma_scan_ctr #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              frame_start,
  input  logic [wnma_pkg::GRID_WIDTH_W-1:0] grid_width,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output logic [$clog2(MAX_HEIGHT+2)-1:0]   row,
  output logic [$clog2(MAX_WIDTH)-1:0]      last_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int WW = CW + 1;
  localparam int GW = wnma_pkg::GRID_WIDTH_W;
  localparam int EW = (WW > GW) ? WW : GW;

  logic [CW-1:0] column, column_next;
  logic [RW-1:0] row_cnt, row_cnt_next;
  logic [EW-1:0] gw_ext, width_eff;
  logic [CW-1:0] col_base;
  logic [RW-1:0] row_base;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] v);
    return (v < RW'(MAX_HEIGHT + 1)) ? v + RW'(1) : v;
  endfunction

  // Width 0 behaves as 1 and anything past the store depth as the depth.
  always_comb begin
    gw_ext = EW'(grid_width);
    if (gw_ext == '0) begin
      width_eff = EW'(1);
    end else if (gw_ext > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = gw_ext;
    end
  end

  assign last_col = CW'(width_eff - EW'(1));

  always_comb begin
    col_base = frame_start ? '0 : column;
    row_base = frame_start ? '0 : row_cnt;
    // A width that shrank under the current column starts a new row.
    if (EW'(col_base) >= width_eff) begin
      col = '0;
      row = row_inc(row_base);
    end else begin
      col = col_base;
      row = row_base;
    end
    if (EW'(col) + EW'(1) >= width_eff) begin
      column_next  = '0;
      row_cnt_next = row_inc(row);
    end else begin
      column_next  = col + CW'(1);
      row_cnt_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column  <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      column  <= column_next;
      row_cnt <= row_cnt_next;
    end
  end

endmodule

@@ sv/wnma_line_store.sv @@
// ----------------------------------------------------------------------------
// wnma_line_store: line store of the two rows above the incoming cell
// One write port and one registered read port, with a bypass when the read
// hits the entry written on the same edge.
// ----------------------------------------------------------------------------
module wnma_line_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output wnma_pkg::store_word_t        rd_q,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  wnma_pkg::store_word_t        wr_data
);

  wnma_pkg::store_word_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= mem[rd_addr];
      end
    end
  end

endmodule

@@ sv/wnma_mask_gen.sv @@
// ----------------------------------------------------------------------------
// wnma_mask_gen: neighbour window and result register
// Keeps the west and centre columns of the 3x3 window, builds the mask of
// the centre cell and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module wnma_mask_gen #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [$clog2(MAX_WIDTH)-1:0]    col,
  input  logic [$clog2(MAX_HEIGHT+2)-1:0] row,
  input  logic [$clog2(MAX_WIDTH)-1:0]    last_col,
  input  wnma_pkg::win_col_t              new_col,
  output logic                            emit,
  wnma_mask_if.source                     mask_stream
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int CRW = (CW > RW) ? CW : RW;
  localparam int PW  = (CRW > wnma_pkg::COORD_W) ? CRW : wnma_pkg::COORD_W;

  // Index 0 is the north row, 1 the centre row, 2 the south row.
  logic [2:0] west_walk;
  logic [2:0] centre_walk;
  logic       centre_wall;
  logic [2:0] east_walk;
  logic       col_zero;
  logic [wnma_pkg::MASK_W-1:0] mask;
  logic [PW-1:0] col_out, row_out;

  assign col_zero = (col == '0);

  // At column 0 the window centre is the last cell of the row two above,
  // and its east side lies outside the grid.
  assign emit      = col_zero ? (row >= RW'(2)) : (row >= RW'(1));
  assign east_walk = col_zero ? 3'b000
                              : {new_col.lower_walk, new_col.centre.walk,
                                 new_col.upper_walk};

  always_comb begin
    mask = '0;
    if (centre_wall) begin
      mask[wnma_pkg::DIR_E]  = east_walk[1];
      mask[wnma_pkg::DIR_S]  = centre_walk[2];
      mask[wnma_pkg::DIR_W]  = west_walk[1];
      mask[wnma_pkg::DIR_N]  = centre_walk[0];
      mask[wnma_pkg::DIR_SE] = east_walk[2];
      mask[wnma_pkg::DIR_SW] = west_walk[2];
      mask[wnma_pkg::DIR_NW] = west_walk[0];
      mask[wnma_pkg::DIR_NE] = east_walk[0];
    end
    col_out = col_zero ? PW'(last_col) : PW'(col) - PW'(1);
    row_out = col_zero ? PW'(row) - PW'(2) : PW'(row) - PW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      west_walk   <= '0;
      centre_walk <= '0;
      centre_wall <= 1'b0;
    end else if (fire) begin
      west_walk   <= col_zero ? 3'b000 : centre_walk;
      centre_walk <= {new_col.lower_walk, new_col.centre.walk, new_col.upper_walk};
      centre_wall <= new_col.centre.wall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_stream.valid <= 1'b0;
    end else begin
      mask_stream.valid <= (mask_stream.valid && !mask_stream.ready) || (fire && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      mask_stream.neighbour_mask <= mask;
      mask_stream.centre_is_wall <= centre_wall;
      mask_stream.cell_col       <= col_out[wnma_pkg::COORD_W-1:0];
      mask_stream.cell_row       <= row_out[wnma_pkg::COORD_W-1:0];
    end
  end

endmodule

@@ sv/wall_neighbour_mask_autotile.sv @@
// ----------------------------------------------------------------------------
// wall_neighbour_mask_autotile: eight-neighbour wall mask over a cell stream
// Classifies raster cells and reports for each cell whether it is a wall and,
// for a wall cell, which of its eight neighbours are walkable.
// ----------------------------------------------------------------------------
// Usage. Cell codes enter on cell_stream in raster order, one item per cycle
// at full rate; frame_start marks cell (0,0) of a new grid. The mask of centre
// (c-1, r-1) is produced by the item for cell (c, r), and the last cell of
// row r-2 by the item for cell (0, r), so after the last row the host sends
// one full row of flush items plus one more. Items in row 0 and the item at
// column 0 of row 1 produce no result. Configuration is written on cfg, only
// while idle, a host rule the block does not enforce; cfg is always ready.
// Flow and rate: an item is accepted into a read stage that addresses the
// line store, and when that stage fires it updates the window, writes the
// store back and loads the result register. One item per cycle is sustained
// while the receiver takes results; the single read and write port of the
// line store is used once per item.
// Reset clears the counters, the window and mask_stream.valid and loads the
// configuration reset values; the line store is not cleared, since rows above
// the grid are masked by the row count. When the receiver stalls, the result
// register holds, and one more item is still taken into the read stage.
// ----------------------------------------------------------------------------
module wall_neighbour_mask_autotile #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input logic         clk,
  input logic         rst,
  wnma_cell_if.sink   cell_stream,
  wnma_mask_if.source mask_stream,
  wnma_cfg_if.sink    cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  wnma_pkg::cfg_regs_t   regs;
  wnma_pkg::cell_bits_t  in_bits;
  wnma_pkg::store_word_t rd_q, wr_word;
  wnma_pkg::win_col_t    new_col;

  logic          accept;
  logic [CW-1:0] scan_col, scan_last;
  logic [RW-1:0] scan_row;

  // Read stage: the item whose line store read is in flight.
  logic                 s1_valid;
  logic [CW-1:0]        s1_col;
  logic [RW-1:0]        s1_row;
  logic [CW-1:0]        s1_last;
  wnma_pkg::cell_bits_t s1_cell;
  logic                 s1_fire;
  logic                 emit;

  assign cfg.ready = 1'b1;

  wnma_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg.valid && cfg.ready),
    .index (cfg.index),
    .data  (cfg.data),
    .regs  (regs)
  );

  // The read stage moves on unless it holds a result the output cannot take.
  assign s1_fire           = s1_valid &&
                             (!emit || !mask_stream.valid || mask_stream.ready);
  assign cell_stream.ready = !s1_valid || s1_fire;
  assign accept            = cell_stream.valid && cell_stream.ready;

  // Flush items are neither walkable nor wall.
  assign in_bits.walk = !cell_stream.flush_item &&
                        ((cell_stream.cell_code == regs.floor_code) ||
                         (cell_stream.cell_code == regs.corridor_code));
  assign in_bits.wall = !cell_stream.flush_item &&
                        (cell_stream.cell_code == regs.wall_code);

  wnma_scan_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan_ctr (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (cell_stream.frame_start),
    .grid_width  (regs.grid_width),
    .col         (scan_col),
    .row         (scan_row),
    .last_col    (scan_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cell_stream.ready) begin
      s1_valid <= cell_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= scan_col;
      s1_row  <= scan_row;
      s1_last <= scan_last;
      s1_cell <= in_bits;
    end
  end

  // Store entries of rows above the grid are ignored and read as not walkable.
  always_comb begin
    new_col.upper_walk = (s1_row >= RW'(2)) ? rd_q.upper_walk : 1'b0;
    new_col.centre     = (s1_row >= RW'(1)) ? rd_q.centre : '0;
    new_col.lower_walk = s1_cell.walk;
    wr_word.upper_walk = new_col.centre.walk;
    wr_word.centre     = s1_cell;
  end

  wnma_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (scan_col),
    .rd_q    (rd_q),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (wr_word)
  );

  wnma_mask_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_mask_gen (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_fire),
    .col         (s1_col),
    .row         (s1_row),
    .last_col    (s1_last),
    .new_col     (new_col),
    .emit        (emit),
    .mask_stream (mask_stream)
  );

  // A read that meets a write to the same entry returns the written word.
  assert property (@(posedge clk) disable iff (rst)
    accept && s1_fire && (s1_col == scan_col) |=> rd_q == $past(wr_word))
    else $error("line store bypass lost a same-entry write");

  // A stalled read stage keeps its item.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_col) && $stable(s1_row))
    else $error("read stage item changed while stalled");

  // The first cell of a grid never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    accept && cell_stream.frame_start |=> !emit)
    else $error("frame start cell produced a result");

  // A result is only loaded when the output register is free or being taken.
  assert property (@(posedge clk) disable iff (rst)
    s1_fire && emit |-> !mask_stream.valid || mask_stream.ready)
    else $error("result register overwritten");

endmodule
